/* rtl/core/tose_pkg.sv */
// shared types, constants and codes of the tagged operand stack engine
`default_nettype none
package tose_pkg;
  localparam int DEPTH = 64;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;
  localparam int VW = 32;
  localparam int HW = 16;
  localparam int DCW = $clog2(VW);

  localparam logic [3:0] OP_PUSHV = 4'd0;
  localparam logic [3:0] OP_PUSHB = 4'd1;
  localparam logic [3:0] OP_POP   = 4'd2;
  localparam logic [3:0] OP_DROP  = 4'd3;
  localparam logic [3:0] OP_ADD   = 4'd4;
  localparam logic [3:0] OP_SUB   = 4'd5;
  localparam logic [3:0] OP_MUL   = 4'd6;
  localparam logic [3:0] OP_SEL   = 4'd7;
  localparam logic [3:0] OP_EXEC  = 4'd8;
  localparam logic [3:0] OP_SWAP  = 4'd9;
  localparam logic [3:0] OP_CLONE = 4'd10;
  localparam logic [3:0] OP_LOOP  = 4'd11;
  localparam logic [3:0] OP_ROT   = 4'd12;
  localparam logic [3:0] OP_REV   = 4'd13;

  localparam logic [1:0] ERR_OK   = 2'd0;
  localparam logic [1:0] ERR_FEW  = 2'd1;
  localparam logic [1:0] ERR_KIND = 2'd2;
  localparam logic [1:0] ERR_FULL = 2'd3;

  localparam logic [1:0] CL_PLAIN = 2'd0;
  localparam logic [1:0] CL_REV   = 2'd1;
  localparam logic [1:0] CL_BAD   = 2'd2;

  typedef struct packed {
    logic [3:0]           op;
    logic signed [VW-1:0] push_value;
    logic [HW-1:0]        block_handle;
  } in_t;

  typedef struct packed {
    logic signed [VW-1:0] popped_value;
    logic [HW-1:0]        chosen_handle;
    logic                 handle_valid;
    logic [1:0]           error_code;
    logic [CW-1:0]        entry_count;
    logic [CW-1:0]        values_held;
    logic [CW-1:0]        blocks_held;
  } out_t;

  typedef struct packed {
    in_t        word;
    logic [1:0] cls;
  } cmd_t;

  typedef struct packed {
    logic          blk;
    logic [VW-1:0] pl;
  } ent_t;
endpackage
`default_nettype wire

/* rtl/core/tagged_operand_stack_engine_core.sv */
// top level of the tagged operand stack engine
// A word is taken when start is high and busy is low; a two-deep queue sits in front
// of the executor, so busy rises only when two words wait. Each word yields one
// result, shown for one cycle with out_strobe; the receiver cannot stall. Push, pop,
// drop, arithmetic, select, execute, clone and loop issue three reads through the
// single read port of the entry memory before they execute; swap adds a second write
// state. Reverse swaps entry pairs from both ends inward through states RVA to RVD;
// rotate runs the bit-serial remainder unit and a copy through a scratch memory.
// The entry memory needs no clearing after reset.
`default_nettype none
module tagged_operand_stack_engine_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire tose_pkg::in_t  in_word,
  output logic                busy,
  output tose_pkg::out_t      out_word,
  output logic                out_strobe
);
  import tose_pkg::*;

  logic q_valid, q_pop;
  cmd_t q_cmd;

  tose_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .in_word(in_word), .busy(busy),
    .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
  );

  tose_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
    .out_word(out_word), .out_strobe(out_strobe)
  );

`ifndef SYNTHESIS
  a_tally_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_word.entry_count == out_word.values_held + out_word.blocks_held)
    else $error("entry count differs from tally sum");
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_word.entry_count <= CW'(DEPTH))
    else $error("entry count above depth");
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.error_code != ERR_OK) |->
      (!out_word.handle_valid && out_word.popped_value == '0))
    else $error("failed word carries data");
`endif
endmodule
`default_nettype wire

/* rtl/core/tose_ram.sv */
// generic single write, single registered read memory
`default_nettype none
module tose_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule
`default_nettype wire

/* rtl/core/tose_front.sv */
// front end: takes words, classifies them and queues them for the back end
`default_nettype none
module tose_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire tose_pkg::in_t in_word,
  output logic               busy,
  output logic               q_valid,
  output tose_pkg::cmd_t     q_cmd,
  input  wire logic          q_pop
);
  import tose_pkg::*;

  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] qn_r;
  logic       push;
  logic [1:0] cls;

  always_comb begin
    case (in_word.op) inside
      OP_REV:             cls = CL_REV;
      [OP_PUSHV:OP_ROT]:  cls = CL_PLAIN;
      default:            cls = CL_BAD;
    endcase
  end

  assign busy    = (qn_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (qn_r != 2'd0);
  assign q_cmd   = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= '{word: in_word, cls: cls};
    end
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      qn_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      qn_r <= 2'(qn_r + {1'b0, push} - {1'b0, q_pop});
    end
  end
endmodule
`default_nettype wire

/* rtl/core/tose_back.sv */
// back end: sequencer that carries out stack operations on the entry memory
`default_nettype none
module tose_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  wire tose_pkg::cmd_t q_cmd,
  output logic                q_pop,
  output tose_pkg::out_t      out_word,
  output logic                out_strobe
);
  import tose_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD1  = 4'd1;
  localparam logic [3:0] S_RD2  = 4'd2;
  localparam logic [3:0] S_EXEC = 4'd3;
  localparam logic [3:0] S_SWAP = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_RCP1 = 4'd6;
  localparam logic [3:0] S_RCP2 = 4'd7;
  localparam logic [3:0] S_RVA  = 4'd8;
  localparam logic [3:0] S_RVB  = 4'd9;
  localparam logic [3:0] S_RVC  = 4'd10;
  localparam logic [3:0] S_RVD  = 4'd11;

  logic [3:0]     st_r, st_nxt;
  cmd_t           cmd_r, cmd_nxt;
  ent_t           t0_r, t0_nxt, t1_r, t1_nxt, hold_r, hold_nxt;
  logic [CW-1:0]  top_r, top_nxt, vt_r, vt_nxt, bt_r, bt_nxt;
  logic [AW-1:0]  ia_r, ia_nxt, ib_r, ib_nxt, base_r, base_nxt;
  logic [AW-1:0]  kq_r, kq_nxt, jq_r, jq_nxt;
  logic [VW-1:0]  sh_r, sh_nxt;
  logic [CW-1:0]  rem_r, rem_nxt, cnt_r, cnt_nxt, k_r, k_nxt, j_r, j_nxt;
  logic [DCW-1:0] dc_r, dc_nxt;
  logic           rdv_r, rdv_nxt;
  out_t           out_r, out_nxt;
  logic           ostb_r;

  logic           m_we, s_we;
  logic [AW-1:0]  m_waddr, m_raddr, s_waddr, s_raddr;
  ent_t           m_wdata, m_rdata, s_wdata, s_rdata;

  logic           fin;
  logic [1:0]     err;
  logic [VW-1:0]  popped;
  logic [HW-1:0]  hnd;
  logic           hv;
  ent_t           t2;
  logic [VW-1:0]  x, y, ar;
  logic [CW:0]    trial;

  tose_ram #(.WIDTH(VW + 1), .DEPTH(DEPTH)) u_stack (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  tose_ram #(.WIDTH(VW + 1), .DEPTH(DEPTH)) u_scratch (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  assign t2 = m_rdata;
  assign x  = t1_r.pl;
  assign y  = t0_r.pl;
  assign trial = {rem_r, sh_r[VW-1]};

  always_comb begin
    case (cmd_r.word.op)
      OP_ADD:  ar = x + y;
      OP_SUB:  ar = x - y;
      default: ar = x * y;
    endcase
  end

  always_comb begin
    st_nxt = st_r;   cmd_nxt = cmd_r;  t0_nxt = t0_r;  t1_nxt = t1_r;
    hold_nxt = hold_r; top_nxt = top_r; vt_nxt = vt_r; bt_nxt = bt_r;
    ia_nxt = ia_r;   ib_nxt = ib_r;    base_nxt = base_r;
    kq_nxt = kq_r;   jq_nxt = jq_r;    sh_nxt = sh_r;  rem_nxt = rem_r;
    cnt_nxt = cnt_r; k_nxt = k_r;      j_nxt = j_r;    dc_nxt = dc_r;
    rdv_nxt = rdv_r;
    q_pop = 1'b0;
    m_we = 1'b0; m_waddr = '0; m_wdata = '0; m_raddr = '0;
    s_we = 1'b0; s_waddr = '0; s_wdata = '0; s_raddr = '0;
    fin = 1'b0; err = ERR_OK; popped = '0; hnd = '0; hv = 1'b0;

    case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          cmd_nxt = q_cmd;
          if (q_cmd.cls == CL_BAD) begin
            fin = 1'b1;
            err = ERR_KIND;
          end else if (q_cmd.cls == CL_REV) begin
            if (top_r < CW'(2)) begin
              fin = 1'b1;
            end else begin
              ia_nxt = '0;
              ib_nxt = AW'(top_r - CW'(1));
              st_nxt = S_RVA;
            end
          end else begin
            m_raddr = AW'(top_r - CW'(1));
            st_nxt = S_RD1;
          end
        end
      end
      S_RD1: begin
        t0_nxt = m_rdata;
        m_raddr = AW'(top_r - CW'(2));
        st_nxt = S_RD2;
      end
      S_RD2: begin
        t1_nxt = m_rdata;
        m_raddr = AW'(top_r - CW'(3));
        st_nxt = S_EXEC;
      end
      S_EXEC: begin
        st_nxt = S_IDLE;
        fin = 1'b1;
        case (cmd_r.word.op)
          OP_PUSHV, OP_PUSHB: begin
            if (top_r >= CW'(DEPTH)) begin
              err = ERR_FULL;
            end else begin
              m_we = 1'b1;
              m_waddr = AW'(top_r);
              top_nxt = top_r + CW'(1);
              if (cmd_r.word.op == OP_PUSHB) begin
                m_wdata = '{blk: 1'b1, pl: VW'(cmd_r.word.block_handle)};
                bt_nxt = bt_r + CW'(1);
              end else begin
                m_wdata = '{blk: 1'b0, pl: cmd_r.word.push_value};
                vt_nxt = vt_r + CW'(1);
              end
            end
          end
          OP_POP: begin
            if (top_r < CW'(1)) err = ERR_FEW;
            else if (t0_r.blk) err = ERR_KIND;
            else begin
              popped = t0_r.pl;
              top_nxt = top_r - CW'(1);
              vt_nxt = vt_r - CW'(1);
            end
          end
          OP_DROP: begin
            if (top_r < CW'(1)) err = ERR_FEW;
            else begin
              top_nxt = top_r - CW'(1);
              if (t0_r.blk) bt_nxt = bt_r - CW'(1);
              else vt_nxt = vt_r - CW'(1);
            end
          end
          OP_ADD, OP_SUB, OP_MUL: begin
            if (top_r < CW'(2)) err = ERR_FEW;
            else if (t0_r.blk || t1_r.blk) err = ERR_KIND;
            else begin
              m_we = 1'b1;
              m_waddr = AW'(top_r - CW'(2));
              m_wdata = '{blk: 1'b0, pl: ar};
              top_nxt = top_r - CW'(1);
              vt_nxt = vt_r - CW'(1);
            end
          end
          OP_SEL: begin
            if (top_r < CW'(3)) err = ERR_FEW;
            else if (!t0_r.blk || !t1_r.blk || t2.blk) err = ERR_KIND;
            else begin
              hnd = (t2.pl != '0) ? HW'(t1_r.pl) : HW'(t0_r.pl);
              hv = 1'b1;
              top_nxt = top_r - CW'(3);
              bt_nxt = bt_r - CW'(2);
              vt_nxt = vt_r - CW'(1);
            end
          end
          OP_EXEC: begin
            if (top_r < CW'(1)) err = ERR_FEW;
            else if (!t0_r.blk) err = ERR_KIND;
            else begin
              hnd = HW'(t0_r.pl);
              hv = 1'b1;
              top_nxt = top_r - CW'(1);
              bt_nxt = bt_r - CW'(1);
            end
          end
          OP_SWAP: begin
            if (top_r < CW'(2)) err = ERR_FEW;
            else begin
              fin = 1'b0;
              m_we = 1'b1;
              m_waddr = AW'(top_r - CW'(1));
              m_wdata = t1_r;
              st_nxt = S_SWAP;
            end
          end
          OP_CLONE: begin
            if (top_r < CW'(1)) err = ERR_FEW;
            else if (top_r >= CW'(DEPTH)) err = ERR_FULL;
            else begin
              m_we = 1'b1;
              m_waddr = AW'(top_r);
              m_wdata = t0_r;
              top_nxt = top_r + CW'(1);
              if (t0_r.blk) bt_nxt = bt_r + CW'(1);
              else vt_nxt = vt_r + CW'(1);
            end
          end
          OP_LOOP: begin
            if (top_r < CW'(2)) err = ERR_FEW;
            else if (t0_r.blk || !t1_r.blk) err = ERR_KIND;
            else if (t0_r.pl == '0) begin
              top_nxt = top_r - CW'(2);
              vt_nxt = vt_r - CW'(1);
              bt_nxt = bt_r - CW'(1);
            end else begin
              m_we = 1'b1;
              m_waddr = AW'(top_r - CW'(1));
              m_wdata = '{blk: 1'b0, pl: t0_r.pl - VW'(1)};
              hnd = HW'(t1_r.pl);
              hv = 1'b1;
            end
          end
          OP_ROT: begin
            if (top_r < CW'(2)) err = ERR_FEW;
            else if (t0_r.blk || t1_r.blk) err = ERR_KIND;
            else if (x == '0 || x[VW-1] || y[VW-1]) err = ERR_KIND;
            else if (x > VW'(top_r - CW'(2))) err = ERR_FEW;
            else begin
              fin = 1'b0;
              cnt_nxt = CW'(x);
              sh_nxt = y;
              rem_nxt = '0;
              dc_nxt = '0;
              base_nxt = AW'(top_r - CW'(3));
              st_nxt = S_DIV;
            end
          end
          default: err = ERR_KIND;
        endcase
      end
      S_SWAP: begin
        m_we = 1'b1;
        m_waddr = AW'(top_r - CW'(2));
        m_wdata = t0_r;
        fin = 1'b1;
        st_nxt = S_IDLE;
      end
      S_DIV: begin
        if (trial >= {1'b0, cnt_r}) rem_nxt = CW'(trial - {1'b0, cnt_r});
        else rem_nxt = CW'(trial);
        sh_nxt = {sh_r[VW-2:0], 1'b0};
        dc_nxt = dc_r + DCW'(1);
        if (dc_r == DCW'(VW - 1)) begin
          k_nxt = rem_nxt;
          j_nxt = '0;
          rdv_nxt = 1'b0;
          st_nxt = S_RCP1;
        end
      end
      S_RCP1: begin
        // old entry j goes to scratch slot (j + step) mod count
        if (rdv_r) begin
          s_we = 1'b1;
          s_waddr = kq_r;
          s_wdata = m_rdata;
        end
        if (j_r < cnt_r) begin
          m_raddr = base_r - AW'(j_r);
          rdv_nxt = 1'b1;
          kq_nxt = AW'(k_r);
          k_nxt = (k_r + CW'(1) == cnt_r) ? '0 : k_r + CW'(1);
          j_nxt = j_r + CW'(1);
        end else begin
          rdv_nxt = 1'b0;
          if (!rdv_r) begin
            j_nxt = '0;
            st_nxt = S_RCP2;
          end
        end
      end
      S_RCP2: begin
        if (rdv_r) begin
          m_we = 1'b1;
          m_waddr = base_r - jq_r;
          m_wdata = s_rdata;
        end
        if (j_r < cnt_r) begin
          s_raddr = AW'(j_r);
          rdv_nxt = 1'b1;
          jq_nxt = AW'(j_r);
          j_nxt = j_r + CW'(1);
        end else begin
          rdv_nxt = 1'b0;
          if (!rdv_r) begin
            fin = 1'b1;
            top_nxt = top_r - CW'(2);
            vt_nxt = vt_r - CW'(2);
            st_nxt = S_IDLE;
          end
        end
      end
      S_RVA: begin
        m_raddr = ia_r;
        st_nxt = S_RVB;
      end
      S_RVB: begin
        hold_nxt = m_rdata;
        m_raddr = ib_r;
        st_nxt = S_RVC;
      end
      S_RVC: begin
        m_we = 1'b1;
        m_waddr = ia_r;
        m_wdata = m_rdata;
        st_nxt = S_RVD;
      end
      S_RVD: begin
        m_we = 1'b1;
        m_waddr = ib_r;
        m_wdata = hold_r;
        ia_nxt = ia_r + AW'(1);
        ib_nxt = ib_r - AW'(1);
        if (ia_r + AW'(1) < ib_r - AW'(1)) begin
          st_nxt = S_RVA;
        end else begin
          fin = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase

    out_nxt = '{popped_value: popped, chosen_handle: hnd, handle_valid: hv,
                error_code: err, entry_count: top_nxt, values_held: vt_nxt,
                blocks_held: bt_nxt};
  end

  assign out_word   = out_r;
  assign out_strobe = ostb_r;

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;   t0_r <= t0_nxt;   t1_r <= t1_nxt;   hold_r <= hold_nxt;
    ia_r <= ia_nxt;     ib_r <= ib_nxt;   base_r <= base_nxt;
    kq_r <= kq_nxt;     jq_r <= jq_nxt;   sh_r <= sh_nxt;   rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;   k_r <= k_nxt;     j_r <= j_nxt;     dc_r <= dc_nxt;
    out_r <= out_nxt;
    if (!rst_n) begin
      st_r   <= S_IDLE;
      top_r  <= '0;
      vt_r   <= '0;
      bt_r   <= '0;
      rdv_r  <= 1'b0;
      ostb_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      top_r  <= top_nxt;
      vt_r   <= vt_nxt;
      bt_r   <= bt_nxt;
      rdv_r  <= rdv_nxt;
      ostb_r <= fin;
    end
  end
endmodule
`default_nettype wire
